[rtl/dwpid_pkg.sv]
// ----------------------------------------------------------------------------
// dwpid_pkg: shared types and constants
// Widths, register indexes, reset values and the serial unit's request and
// response structs for the dual wheel position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dwpid_pkg;

    // Field widths
    localparam int STEP_W    = 16;
    localparam int LIM_W     = 15;
    localparam int GAIN_W    = 48;
    localparam int EL_W      = 16;
    localparam int DRV_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Serial arithmetic widths
    localparam int MCAND_W   = 64;
    localparam int PROD_W    = MCAND_W + GAIN_W;
    localparam int TERM_W    = 61;
    localparam int CNT_W     = 7;
    localparam int MUL_STEPS = GAIN_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int SUM_W     = 64;

    // Signed PID sum and the Q0.48 to Q0.15 conversion
    localparam int U_W         = 63;
    localparam int DRIVE_SHIFT = 33;

    localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

    // Reset values
    localparam logic [LIM_W-1:0]  LIMIT_RST  = 15'd16384;
    localparam logic [GAIN_W-1:0] GAIN_P_RST = 48'd281193501734;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 48'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 48'd281474976711;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_RIGHT  = 3'd0,
        REG_STEP_LEFT   = 3'd1,
        REG_LIMIT_RIGHT = 3'd2,
        REG_LIMIT_LEFT  = 3'd3,
        REG_GAIN_P      = 3'd4,
        REG_GAIN_I      = 3'd5,
        REG_GAIN_D      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [STEP_W-1:0] step_right;
        logic signed [STEP_W-1:0] step_left;
        logic [LIM_W-1:0]         limit_right;
        logic [LIM_W-1:0]         limit_left;
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_i;
        logic [GAIN_W-1:0]        gain_d;
    } cfg_t;

    // Serial unit operations
    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    typedef struct packed {
        logic               start;
        op_t                op;
        logic [MCAND_W-1:0] mcand;
        logic [GAIN_W-1:0]  mplier;
        logic [EL_W-1:0]    divisor;
    } unit_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
        logic [TERM_W-1:0] term;
    } unit_rsp_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

endpackage

`default_nettype wire

[rtl/dwpid_unit.sv]
// ----------------------------------------------------------------------------
// dwpid_unit: bit-serial multiply and divide
// Shift-and-add multiply, one multiplier bit per cycle, and restoring divide
// of the held product, one quotient bit per cycle, saturated at 2^60.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpid_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dwpid_pkg::unit_req_t req,
    output dwpid_pkg::unit_rsp_t rsp
);
    import dwpid_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    op_t               op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [MCAND_W-1:0] mcand_reg;
    logic [EL_W-1:0]   dvsr_reg;
    logic [EL_W-1:0]   rem_reg;
    logic [TERM_W-1:0] quo_reg;
    logic              qsat_reg;

    logic [MCAND_W:0]  acc_sum;
    logic [EL_W:0]     div_trial;
    logic [EL_W:0]     div_diff;
    logic              div_ge;

    // One step of each operation
    always_comb
    begin
        acc_sum   = {1'b0, prod_reg[PROD_W-1:GAIN_W]}
                  + (prod_reg[0] ? {1'b0, mcand_reg} : {(MCAND_W+1){1'b0}});
        div_trial = {rem_reg, prod_reg[PROD_W-1]};
        div_diff  = div_trial - {1'b0, dvsr_reg};
        div_ge    = (div_trial >= {1'b0, dvsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                if (req.op == OP_MUL)
                begin
                    cnt_reg   <= CNT_W'(MUL_STEPS - 1);
                    prod_reg  <= {{MCAND_W{1'b0}}, req.mplier};
                    mcand_reg <= req.mcand;
                end
                else
                begin
                    // divide runs on the product left by the last multiply
                    cnt_reg  <= CNT_W'(DIV_STEPS - 1);
                    dvsr_reg <= req.divisor;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    qsat_reg <= 1'b0;
                end
            end
            else if (busy_reg)
            begin
                if (op_reg == OP_MUL)
                begin
                    prod_reg <= {acc_sum, prod_reg[GAIN_W-1:1]};
                end
                else
                begin
                    prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
                    rem_reg  <= div_ge ? div_diff[EL_W-1:0] : div_trial[EL_W-1:0];
                    quo_reg  <= {quo_reg[TERM_W-2:0], div_ge};
                    qsat_reg <= qsat_reg | quo_reg[TERM_W-1];
                end
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Result, capped at 2^60
    always_comb
    begin
        rsp.done = done_reg;
        rsp.prod = prod_reg;
        if (op_reg == OP_MUL)
        begin
            rsp.term = (|prod_reg[PROD_W-1:TERM_W-1]) ? TERM_CAP
                     : {1'b0, prod_reg[TERM_W-2:0]};
        end
        else
        begin
            rsp.term = (qsat_reg | quo_reg[TERM_W-1]) ? TERM_CAP : quo_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/dwpid_core.sv]
// ----------------------------------------------------------------------------
// dwpid_core: per-wheel PID sequencer
// Walks right then left wheel through goal, error, integral and the three
// gain terms using the shared serial unit, and keeps the controller state.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpid_core #(
    parameter int POS_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  dwpid_pkg::cfg_t                   cfg,
    input  logic [dwpid_pkg::EL_W-1:0]        elapsed,
    input  logic signed [POS_BITS-1:0]        pos_r,
    input  logic signed [POS_BITS-1:0]        pos_l,
    input  logic                              take,
    output dwpid_pkg::core_stat_t             stat,
    output logic signed [dwpid_pkg::DRV_W-1:0] drive_r,
    output logic signed [dwpid_pkg::DRV_W-1:0] drive_l,
    output logic                              halted_r,
    output logic                              halted_l
);
    import dwpid_pkg::*;

    localparam int EW = POS_BITS + 1;
    localparam int DW = POS_BITS + 2;
    localparam int SHR_W = U_W - DRIVE_SHIFT;
    localparam logic signed [POS_BITS-1:0] GMAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] GMIN = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_GOAL   = 12'b000000000010,
        ST_ERR    = 12'b000000000100,
        ST_DERR   = 12'b000000001000,
        ST_MSUM   = 12'b000000010000,
        ST_SUMADD = 12'b000000100000,
        ST_MP     = 12'b000001000000,
        ST_MD     = 12'b000010000000,
        ST_DV     = 12'b000100000000,
        ST_MI     = 12'b001000000000,
        ST_OUT    = 12'b010000000000,
        ST_FIN    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;

    logic [EL_W-1:0]             elapsed_reg;
    logic signed [POS_BITS-1:0]  pos_reg  [2];
    logic signed [POS_BITS-1:0]  goal_reg [2];
    logic signed [EW-1:0]        last_reg [2];
    logic signed [SUM_W-1:0]     sum_reg  [2];
    logic signed [DRV_W-1:0]     drive_reg [2];
    logic                        halt_reg [2];
    logic signed [EW-1:0]        e_reg, e_next;
    logic signed [DW-1:0]        de_reg, de_next;
    logic signed [U_W-1:0]       u_reg, u_next;

    logic signed [POS_BITS-1:0]  goal_next;
    logic signed [SUM_W-1:0]     sum_next;
    logic signed [DRV_W-1:0]     drive_next;
    logic                        halt_next;
    logic                        goal_we, sum_we, out_we;

    logic signed [STEP_W-1:0]    cur_step;
    logic [LIM_W-1:0]            cur_limit;
    logic signed [POS_BITS-1:0]  cur_pos, cur_goal;
    logic signed [EW-1:0]        cur_last;
    logic signed [SUM_W-1:0]     cur_sum;

    logic signed [EW-1:0]        gsum;
    logic [EW-1:0]               e_mag;
    logic [DW-1:0]               de_mag;
    logic [SUM_W-1:0]            sum_mag;
    logic signed [SUM_W-1:0]     sum_inc, sum_raw;
    logic                        term_neg;
    logic signed [U_W-1:0]       term_s;
    logic [U_W-1:0]              u_mag;
    logic [SHR_W-1:0]            u_shr;
    logic [LIM_W-1:0]            mag;

    unit_req_t req;
    unit_rsp_t rsp;

    dwpid_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Selected wheel
    always_comb
    begin
        cur_step  = sel_reg ? cfg.step_left   : cfg.step_right;
        cur_limit = sel_reg ? cfg.limit_left  : cfg.limit_right;
        cur_pos   = pos_reg[sel_reg];
        cur_goal  = goal_reg[sel_reg];
        cur_last  = last_reg[sel_reg];
        cur_sum   = sum_reg[sel_reg];
    end

    // Datapath pieces
    always_comb
    begin
        gsum      = EW'(cur_goal) + EW'(cur_step);
        goal_next = (gsum[EW-1] != gsum[EW-2]) ? (gsum[EW-1] ? GMIN : GMAX)
                  : gsum[POS_BITS-1:0];
        e_mag     = e_reg[EW-1] ? EW'(-e_reg) : EW'(e_reg);
        de_mag    = de_reg[DW-1] ? DW'(-de_reg) : DW'(de_reg);
        sum_mag   = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);

        // integral: saturating add of e * elapsed
        sum_inc   = e_reg[EW-1] ? -signed'(rsp.prod[SUM_W-1:0])
                                : signed'(rsp.prod[SUM_W-1:0]);
        sum_raw   = cur_sum + sum_inc;
        if ((cur_sum[SUM_W-1] == sum_inc[SUM_W-1]) && (sum_raw[SUM_W-1] != cur_sum[SUM_W-1]))
        begin
            sum_next = cur_sum[SUM_W-1] ? SMIN : SMAX;
        end
        else
        begin
            sum_next = sum_raw;
        end

        // signed term into the running PID sum
        case (state_reg)
            ST_MP:   term_neg = e_reg[EW-1];
            ST_DV:   term_neg = de_reg[DW-1];
            default: term_neg = cur_sum[SUM_W-1];
        endcase
        term_s = term_neg ? -signed'(U_W'(rsp.term)) : signed'(U_W'(rsp.term));

        // drive: |u| in Q0.15, clamp, sign from step, zero when halted
        u_mag = u_reg[U_W-1] ? U_W'(-u_reg) : U_W'(u_reg);
        u_shr = u_mag[U_W-1:DRIVE_SHIFT];
        mag   = (u_shr > SHR_W'(cur_limit)) ? cur_limit : u_shr[LIM_W-1:0];
        halt_next  = (cur_pos >= POS_BITS'(cur_step));
        drive_next = halt_next ? '0
                   : (cur_step[STEP_W-1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag}));
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        e_next     = e_reg;
        de_next    = de_reg;
        u_next     = u_reg;
        goal_we    = 1'b0;
        sum_we     = 1'b0;
        out_we     = 1'b0;
        req        = '0;
        stat.idle  = (state_reg == ST_IDLE);
        stat.done  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sel_next   = 1'b0;
                    state_next = ST_GOAL;
                end
            end
            ST_GOAL:
            begin
                goal_we    = 1'b1;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                e_next     = EW'(cur_goal) - EW'(cur_pos);
                state_next = ST_DERR;
            end
            ST_DERR:
            begin
                de_next     = DW'(e_reg) - DW'(cur_last);
                u_next      = '0;
                req.start   = 1'b1;
                req.op      = OP_MUL;
                req.mcand   = MCAND_W'(e_mag);
                req.mplier  = GAIN_W'(elapsed_reg);
                state_next  = ST_MSUM;
            end
            ST_MSUM:
            begin
                if (rsp.done)
                begin
                    state_next = ST_SUMADD;
                end
            end
            ST_SUMADD:
            begin
                sum_we      = 1'b1;
                req.start   = 1'b1;
                req.op      = OP_MUL;
                req.mcand   = MCAND_W'(e_mag);
                req.mplier  = cfg.gain_p;
                state_next  = ST_MP;
            end
            ST_MP:
            begin
                if (rsp.done)
                begin
                    u_next    = u_reg + term_s;
                    req.start = 1'b1;
                    req.op    = OP_MUL;
                    if (elapsed_reg != '0)
                    begin
                        req.mcand  = MCAND_W'(de_mag);
                        req.mplier = cfg.gain_d;
                        state_next = ST_MD;
                    end
                    else
                    begin
                        req.mcand  = sum_mag;
                        req.mplier = cfg.gain_i;
                        state_next = ST_MI;
                    end
                end
            end
            ST_MD:
            begin
                if (rsp.done)
                begin
                    req.start   = 1'b1;
                    req.op      = OP_DIV;
                    req.divisor = elapsed_reg;
                    state_next  = ST_DV;
                end
            end
            ST_DV:
            begin
                if (rsp.done)
                begin
                    u_next     = u_reg + term_s;
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.mcand  = sum_mag;
                    req.mplier = cfg.gain_i;
                    state_next = ST_MI;
                end
            end
            ST_MI:
            begin
                if (rsp.done)
                begin
                    u_next     = u_reg + term_s;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_we = 1'b1;
                if (sel_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = ST_GOAL;
                end
            end
            ST_FIN:
            begin
                if (take)
                begin
                    stat.done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                goal_reg[i] <= '0;
                last_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            if (goal_we)
            begin
                goal_reg[sel_reg] <= goal_next;
            end
            if (sum_we)
            begin
                sum_reg[sel_reg] <= sum_next;
            end
            if (out_we)
            begin
                last_reg[sel_reg] <= e_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (stat.idle && start)
        begin
            elapsed_reg <= elapsed;
            pos_reg[0]  <= pos_r;
            pos_reg[1]  <= pos_l;
        end
        e_reg  <= e_next;
        de_reg <= de_next;
        u_reg  <= u_next;
        if (out_we)
        begin
            drive_reg[sel_reg] <= drive_next;
            halt_reg[sel_reg]  <= halt_next;
        end
    end

    assign drive_r  = drive_reg[0];
    assign drive_l  = drive_reg[1];
    assign halted_r = halt_reg[0];
    assign halted_l = halt_reg[1];

endmodule

`default_nettype wire

[rtl/dual_wheel_pid_position_control.sv]
// ----------------------------------------------------------------------------
// dual_wheel_pid_position_control: two-wheel PID position controller
// Per control tick, advances each wheel's goal and produces a clamped Q1.15
// drive from proportional, integral and derivative terms.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_ready): elapsed_us, pos_right, pos_left.
//   Output beat (out_valid/out_ready): drive_right, drive_left, halted_right,
//   halted_left; exactly one output beat per input beat.
//   Config: cfg_we writes cfg_data into register cfg_index (0 step_right,
//   1 step_left, 2 limit_right, 3 limit_left, 4 gain_p, 5 gain_i, 6 gain_d).
//   One tick at a time. Each wheel uses the single bit-serial unit for four
//   multiplies and one divide, or three multiplies and no divide when
//   elapsed_us is zero; wheels in turn. in_ready is high whenever the
//   sequencer is idle.
//   A finished result waits in the output register; the next tick can be
//   accepted while it waits, and its result is held back until the output
//   register has been taken.
//   Reset clears goals, errors and integrals, and loads default gains/limits.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_wheel_pid_position_control #(
    parameter int POS_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [dwpid_pkg::EL_W-1:0]             elapsed_us,
    input  logic signed [31:0]                     pos_right,
    input  logic signed [31:0]                     pos_left,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [dwpid_pkg::DRV_W-1:0]     drive_right,
    output logic signed [dwpid_pkg::DRV_W-1:0]     drive_left,
    output logic                                   halted_right,
    output logic                                   halted_left,
    input  logic                                   cfg_we,
    input  logic [dwpid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dwpid_pkg::GAIN_W-1:0]           cfg_data
);
    import dwpid_pkg::*;

    cfg_t       cfg_reg;
    core_stat_t stat;
    logic       out_valid_reg;
    logic       take;
    logic       start;

    logic signed [DRV_W-1:0] core_drive_r, core_drive_l;
    logic                    core_halt_r, core_halt_l;
    logic signed [DRV_W-1:0] drive_r_reg, drive_l_reg;
    logic                    halt_r_reg, halt_l_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_right  <= '0;
            cfg_reg.step_left   <= '0;
            cfg_reg.limit_right <= LIMIT_RST;
            cfg_reg.limit_left  <= LIMIT_RST;
            cfg_reg.gain_p      <= GAIN_P_RST;
            cfg_reg.gain_i      <= GAIN_I_RST;
            cfg_reg.gain_d      <= GAIN_D_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_STEP_RIGHT:  cfg_reg.step_right  <= signed'(cfg_data[STEP_W-1:0]);
                REG_STEP_LEFT:   cfg_reg.step_left   <= signed'(cfg_data[STEP_W-1:0]);
                REG_LIMIT_RIGHT: cfg_reg.limit_right <= cfg_data[LIM_W-1:0];
                REG_LIMIT_LEFT:  cfg_reg.limit_left  <= cfg_data[LIM_W-1:0];
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_data;
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_data;
                REG_GAIN_D:      cfg_reg.gain_d      <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input beat starts the sequencer
    assign in_ready = stat.idle;
    assign start    = in_valid && in_ready;
    assign take     = !out_valid_reg || out_ready;

    dwpid_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cfg      (cfg_reg),
        .elapsed  (elapsed_us),
        .pos_r    (pos_right[POS_BITS-1:0]),
        .pos_l    (pos_left[POS_BITS-1:0]),
        .take     (take),
        .stat     (stat),
        .drive_r  (core_drive_r),
        .drive_l  (core_drive_l),
        .halted_r (core_halt_r),
        .halted_l (core_halt_l)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            drive_r_reg <= core_drive_r;
            drive_l_reg <= core_drive_l;
            halt_r_reg  <= core_halt_r;
            halt_l_reg  <= core_halt_l;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_right  = drive_r_reg;
    assign drive_left   = drive_l_reg;
    assign halted_right = halt_r_reg;
    assign halted_left  = halt_l_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sequencer idle right after an input beat");

    a_done_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (!out_valid || out_ready))
        else $error("result finished over an untaken output beat");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !in_ready)
        else $error("result finished while sequencer idle");

endmodule

`default_nettype wire

[tb/sv/dual_wheel_pid_position_control_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_pid_position_control_tb: self-checking bench for the PID block
// Drives control ticks through the valid/ready input with random gaps, keeps
// its own per-wheel PID state to predict every drive beat, and compares the
// output beats in order. Runs several register settings, extremes included.
// ----------------------------------------------------------------------------

module dual_wheel_pid_position_control_tb;

    import dwpid_pkg::*;

    localparam logic [63:0] SAT_TERM = 64'h1000_0000_0000_0000;
    localparam longint GOAL_MAX = 64'sh7FFF_FFFF;
    localparam longint GOAL_MIN = -64'sh8000_0000;

    typedef struct {
        logic signed [DRV_W-1:0] drv_r;
        logic signed [DRV_W-1:0] drv_l;
        logic                    hlt_r;
        logic                    hlt_l;
    } wheel_cmd_t;

    // Scoreboard: mirrors the controller state and holds pending drive beats
    class pid_scoreboard;
        logic signed [STEP_W-1:0] step[2];
        logic [LIM_W-1:0]         limit[2];
        logic [GAIN_W-1:0]        kp, ki, kd;
        logic signed [63:0]       goal[2];
        logic signed [63:0]       last_err[2];
        logic signed [63:0]       sum_err[2];
        wheel_cmd_t               pending_cmds[$];
        int                       mismatches;

        function new();
            for (int w = 0; w < 2; w++)
            begin
                step[w]     = '0;
                limit[w]    = LIMIT_RST;
                goal[w]     = 0;
                last_err[w] = 0;
                sum_err[w]  = 0;
            end
            kp = GAIN_P_RST;
            ki = GAIN_I_RST;
            kd = GAIN_D_RST;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [GAIN_W-1:0] v);
            case (idx)
                REG_STEP_RIGHT:  step[0]  = v[STEP_W-1:0];
                REG_STEP_LEFT:   step[1]  = v[STEP_W-1:0];
                REG_LIMIT_RIGHT: limit[0] = v[LIM_W-1:0];
                REG_LIMIT_LEFT:  limit[1] = v[LIM_W-1:0];
                REG_GAIN_P:      kp = v;
                REG_GAIN_I:      ki = v;
                REG_GAIN_D:      kd = v;
                default: ;
            endcase
        endfunction

        function logic [63:0] magnitude(logic signed [63:0] v);
            return v < 0 ? -v : v;
        endfunction

        // gain times magnitude, saturated at 2^60
        function logic [63:0] capped(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = a * b;
            return (p > SAT_TERM) ? SAT_TERM : p[63:0];
        endfunction

        function logic signed [63:0] signed_by(logic [63:0] m, logic signed [63:0] s);
            return s < 0 ? -$signed(m) : $signed(m);
        endfunction

        // One wheel of one tick; updates the kept goal, error and integral
        function void predict_wheel(int w, logic [EL_W-1:0] el, logic signed [31:0] pos,
                                    output logic signed [DRV_W-1:0] drv,
                                    output logic hlt);
            logic signed [63:0] g, e, de, add, u, d;
            logic signed [65:0] s;
            logic [63:0]        tp, td, ti, ade, qt, rm, lo, mag;
            g = goal[w] + step[w];
            if (g > GOAL_MAX) g = GOAL_MAX;
            if (g < GOAL_MIN) g = GOAL_MIN;
            goal[w] = g;
            e  = g - pos;
            de = e - last_err[w];
            add = e * $signed({48'b0, el});
            s = sum_err[w];
            s = s + add;
            if (s > 66'sh0_7FFF_FFFF_FFFF_FFFF) sum_err[w] = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (s < -66'sh0_8000_0000_0000_0000) sum_err[w] = 64'h8000_0000_0000_0000;
            else sum_err[w] = s[63:0];
            tp = capped(kp, magnitude(e));
            td = 0;
            if (el != 0)
            begin
                ade = magnitude(de);
                qt  = ade / el;
                rm  = ade % el;
                lo  = (64'(kd) * rm) / el;
                td  = capped(kd, qt) + lo;
                if (td > SAT_TERM) td = SAT_TERM;
            end
            ti = capped(ki, magnitude(sum_err[w]));
            u = signed_by(tp, e) + signed_by(td, de) + signed_by(ti, sum_err[w]);
            mag = magnitude(u) >> DRIVE_SHIFT;
            if (mag > limit[w]) mag = limit[w];
            d = step[w] < 0 ? -$signed(mag) : $signed(mag);
            hlt = (pos >= step[w]);
            drv = hlt ? '0 : d[DRV_W-1:0];
            last_err[w] = e;
        endfunction

        function void note_tick(logic [EL_W-1:0] el, logic signed [31:0] pr,
                                logic signed [31:0] pl);
            wheel_cmd_t c;
            predict_wheel(0, el, pr, c.drv_r, c.hlt_r);
            predict_wheel(1, el, pl, c.drv_l, c.hlt_l);
            pending_cmds.push_back(c);
        endfunction

        function void check_cmd(wheel_cmd_t got);
            wheel_cmd_t exp_c;
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected drive beat: dr=%0d dl=%0d hr=%0b hl=%0b",
                             got.drv_r, got.drv_l, got.hlt_r, got.hlt_l);
                return;
            end
            exp_c = pending_cmds.pop_front();
            if (got.drv_r !== exp_c.drv_r || got.drv_l !== exp_c.drv_l ||
                got.hlt_r !== exp_c.hlt_r || got.hlt_l !== exp_c.hlt_l)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("drive mismatch: exp dr=%0d dl=%0d hr=%0b hl=%0b, got dr=%0d dl=%0d hr=%0b hl=%0b",
                             exp_c.drv_r, exp_c.drv_l, exp_c.hlt_r, exp_c.hlt_l,
                             got.drv_r, got.drv_l, got.hlt_r, got.hlt_l);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [EL_W-1:0]          elapsed_us;
    logic signed [31:0]       pos_right;
    logic signed [31:0]       pos_left;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DRV_W-1:0]  drive_right;
    logic signed [DRV_W-1:0]  drive_left;
    logic                     halted_right;
    logic                     halted_left;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [GAIN_W-1:0]        cfg_data;

    pid_scoreboard sb;
    logic          long_hold;
    logic          tx_burst;

    dual_wheel_pid_position_control dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .elapsed_us   (elapsed_us),
        .pos_right    (pos_right),
        .pos_left     (pos_left),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_right  (drive_right),
        .drive_left   (drive_left),
        .halted_right (halted_right),
        .halted_left  (halted_left),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #40_000_000;
        $display("dual_wheel_pid_position_control_tb: errors");
        $finish;
    end

    // Register write, called at a falling edge while the block is idle;
    // the caller drops cfg_we after the last write
    task automatic write_cfg(cfg_idx_t idx, logic [GAIN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        sb.write_reg(idx, v);
    endtask

    // One tick beat; starts and ends at a falling edge
    task automatic send_tick(logic [EL_W-1:0] el, logic signed [31:0] pr,
                             logic signed [31:0] pl);
        int gap;
        if ($urandom_range(0, 59) == 0) tx_burst = ~tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        elapsed_us <= el;
        pos_right  <= pr;
        pos_left   <= pl;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(el, pr, pl);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] rand_gain();
        return {$urandom, $urandom} >> $urandom_range(0, 47);
    endfunction

    function automatic logic [EL_W-1:0] rand_elapsed();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            default: return $urandom_range(1, 20000);
        endcase
    endfunction

    // Position mostly close to the wheel's next goal, sometimes anywhere
    function automatic logic signed [31:0] rand_pos(int w);
        longint p;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2:       return sb.step[w] + $signed($urandom_range(0, 4)) - 2;
            3:       p = sb.goal[w] + sb.step[w] + $signed($urandom_range(0, 2000000)) - 1000000;
            default: p = sb.goal[w] + sb.step[w] + $signed($urandom_range(0, 8000)) - 4000;
        endcase
        if (p > GOAL_MAX) p = GOAL_MAX;
        if (p < GOAL_MIN) p = GOAL_MIN;
        return p[31:0];
    endfunction

    task automatic set_phase(int n);
        logic [GAIN_W-1:0] v[7];
        case (n)
            0: v = '{48'd50, 48'hFFFF_FFFF_FFCE, LIMIT_RST, LIMIT_RST,
                     GAIN_P_RST, 48'd2000, GAIN_D_RST};
            1: v = '{48'h7FFF, 48'h8000, 48'h7FFF, 48'h7FFF, '1, '1, '1};
            2: v = '{48'h8000, 48'h7FFF, 48'd0, 48'd0, '0, '0, '0};
            3: v = '{48'($urandom_range(0, 400)), 48'($urandom_range(0, 400)),
                     48'($urandom_range(0, 32767)), 48'($urandom_range(0, 32767)),
                     48'($urandom) << 8, 48'($urandom_range(0, 65535)), 48'($urandom) << 12};
            default: v = '{48'($urandom), 48'($urandom), 48'($urandom), 48'($urandom),
                           rand_gain(), rand_gain(), rand_gain()};
        endcase
        for (int i = 0; i < 7; i++) write_cfg(cfg_idx_t'(i), v[i]);
        cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls, one long hold-off to back up the input
    initial
    begin
        int hold;
        logic rx_burst;
        wheel_cmd_t got;
        out_ready = 1'b0;
        rx_burst  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 59) == 0) rx_burst = ~rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 18);
            if (long_hold)
            begin
                hold = 3000;
                long_hold = 1'b0;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.drv_r = drive_right;
            got.drv_l = drive_left;
            got.hlt_r = halted_right;
            got.hlt_l = halted_left;
            sb.check_cmd(got);
        end
    end

    // Stimulus
    initial
    begin
        sb = new();
        long_hold  = 1'b0;
        tx_burst   = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        elapsed_us = '0;
        pos_right  = '0;
        pos_left   = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed ticks at reset settings: field extremes, zero elapsed time
        send_tick(16'd0, 32'sd0, 32'sd0);
        send_tick(16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(16'd1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_tick(16'd0, -32'sd1, 32'sd1);
        send_tick(16'd0, -32'sd5000, 32'sd5000);
        send_tick(16'd1000, -32'sd5000, -32'sd40000);
        send_tick(16'hFFFF, 32'sd0, -32'sd1);
        send_tick(16'd7, -32'sd3, -32'sd100000);
        send_tick(16'h5555, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_tick(16'hAAAA, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_tick(16'd3, -32'sd16000000, -32'sd16000000);
        send_tick(16'd0, -32'sd16000000, -32'sd16000000);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            set_phase(ph);
            for (int i = 0; i < 148; i++)
            begin
                if (ph == 3 && i == 40) long_hold = 1'b1;
                send_tick(rand_elapsed(), rand_pos(0), rand_pos(1));
            end
            wait_drained();
        end

        repeat (700) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
            $display("dual_wheel_pid_position_control_tb: clean");
        else
            $display("dual_wheel_pid_position_control_tb: errors");
        $finish;
    end

endmodule
